// ----- rtl/smtp_eod_pkg.sv -----
// Shared types and constants for the SMTP end-of-data destuffer.
package smtp_eod_pkg;

  localparam logic [7:0]  ChCr  = 8'h0D;
  localparam logic [7:0]  ChLf  = 8'h0A;
  localparam logic [7:0]  ChDot = 8'h2E;

  localparam int unsigned CountW = 17;
  localparam int unsigned LimitW = 16;
  localparam int unsigned MaxRes = 3;

  localparam logic [LimitW-1:0] ChunkLimitRst = 16'd30000;

  // Register indexes on the configuration port
  localparam logic RegChunkLimit = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_CR          = 3'd1,
    PH_CRLF        = 3'd2,
    PH_CRLF_DOT    = 3'd3,
    PH_CRLF_DOT_CR = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       message_end;
    logic       chunk_end;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic    [1:0]        count;
  } step_t;

  function automatic phase_e after_byte(logic [7:0] c);
    return (c == ChCr) ? PH_CR : PH_IDLE;
  endfunction

endpackage

// ----- rtl/smtp_eod_detect.sv -----
// Terminator detector, dot unstuffing and chunk byte counter.
module smtp_eod_detect (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 message_start_i,
  input  logic [smtp_eod_pkg::LimitW-1:0]      chunk_limit_i,
  output smtp_eod_pkg::step_t                  step_o
);
  import smtp_eod_pkg::*;

  phase_e              phase_q, phase_d, phase_cur;
  logic [CountW-1:0]   count_q, count_d, count_cur, count_sum;
  logic [7:0]          b0, b1, b2;
  logic [1:0]          nbytes;
  logic                eom;
  logic                close;

  assign phase_cur = message_start_i ? PH_IDLE : phase_q;
  assign count_cur = message_start_i ? '0 : count_q;

  // Bytes delivered for this input
  always_comb begin
    b0     = data_byte_i;
    b1     = 8'h00;
    b2     = 8'h00;
    nbytes = 2'd1;
    eom    = 1'b0;
    unique case (phase_cur)
      PH_CRLF: begin
        if (data_byte_i == ChDot) nbytes = 2'd0;
      end
      PH_CRLF_DOT: begin
        if (data_byte_i == ChCr) begin
          nbytes = 2'd0;
        end else if (data_byte_i != ChDot) begin
          b0     = ChDot;
          b1     = data_byte_i;
          nbytes = 2'd2;
        end
      end
      PH_CRLF_DOT_CR: begin
        if (data_byte_i == ChLf) begin
          nbytes = 2'd0;
          eom    = 1'b1;
        end else begin
          b0     = ChDot;
          b1     = ChCr;
          b2     = data_byte_i;
          nbytes = 2'd3;
        end
      end
      default: ;
    endcase
  end

  assign count_sum = count_cur + {{(CountW-2){1'b0}}, nbytes};
  assign close     = (nbytes != 2'd0) && (count_sum >= {1'b0, chunk_limit_i});

  always_comb begin
    step_o = '0;
    if (eom) begin
      step_o.count              = 2'd1;
      step_o.res[0].last        = 1'b1;
      step_o.res[0].message_end = 1'b1;
    end else begin
      step_o.count              = nbytes;
      step_o.res[0].out_byte    = b0;
      step_o.res[1].out_byte    = b1;
      step_o.res[2].out_byte    = b2;
      for (int k = 0; k < MaxRes; k++) begin
        step_o.res[k].byte_valid = 1'b1;
        step_o.res[k].last       = (2'(k + 1) == nbytes);
        step_o.res[k].chunk_end  = (2'(k + 1) == nbytes) && close;
      end
    end
  end

  // Next phase and count
  always_comb begin
    unique case (phase_cur)
      PH_CR:
        phase_d = (data_byte_i == ChLf) ? PH_CRLF : after_byte(data_byte_i);
      PH_CRLF:
        phase_d = (data_byte_i == ChDot) ? PH_CRLF_DOT : after_byte(data_byte_i);
      PH_CRLF_DOT:
        phase_d = (data_byte_i == ChCr) ? PH_CRLF_DOT_CR : PH_IDLE;
      PH_CRLF_DOT_CR:
        phase_d = (data_byte_i == ChLf) ? PH_IDLE : after_byte(data_byte_i);
      default:
        phase_d = after_byte(data_byte_i);
    endcase

    if (eom || close) begin
      count_d = '0;
    end else begin
      count_d = count_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && eom |=> count_q == '0 && phase_q == PH_IDLE)
    else $error("end marker did not clear detector");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && phase_cur == PH_CRLF && data_byte_i == ChDot |-> step_o.count == 2'd0)
    else $error("line-leading dot not held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= {1'b0, {LimitW{1'b1}}} + CountW'(MaxRes))
    else $error("chunk count ran past limit range");

endmodule

// ----- rtl/smtp_eod_outbuf.sv -----
// Result register bank: holds up to three results of one request, sends one per cycle while m_tready is high.
module smtp_eod_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  smtp_eod_pkg::step_t  step_i,
  output logic                 can_load_o,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,  // out_byte
  output logic [2:0]           m_tuser,  // byte_valid, message_end, chunk_end
  output logic                 m_tlast
);
  import smtp_eod_pkg::*;

  result_t [MaxRes-1:0] res_q;
  logic    [1:0]        rem_q, ptr_q;
  result_t              cur;
  logic                 pop;

  assign cur        = res_q[ptr_q];
  assign m_tvalid   = (rem_q != 2'd0);
  assign pop        = m_tvalid && m_tready;
  assign can_load_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_tready);

  assign m_tdata = cur.out_byte;
  assign m_tuser = {cur.chunk_end, cur.message_end, cur.byte_valid};
  assign m_tlast = cur.last;

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= step_i.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      ptr_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= step_i.count;
      ptr_q <= 2'd0;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
      ptr_q <= ptr_q + 2'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ptr_q} + {1'b0, rem_q}) <= 3'(MaxRes))
    else $error("result pointer past bank");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && rem_q == 2'd1 |-> m_tlast)
    else $error("final result lacks tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (cur.message_end || cur.chunk_end) |-> m_tlast)
    else $error("marker flag on non-final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && cur.message_end |-> !cur.chunk_end && !cur.byte_valid)
    else $error("end marker carries data flags");

endmodule

// ----- rtl/smtp_end_of_data_destuffer.sv -----
// Top level: SMTP end-of-data detector with dot unstuffing and chunk counting.
// An accepted request is held in the input register, then its results are loaded into the output bank.
// Throughput: 1 request per cycle while m_tready is high and each request gives at most one result;
//   a request giving two or three results holds the input until its last result is being sent (output bank).
// Reset (async, rst_ni low): detector idle, chunk count zero, chunk_limit 30000,
//   input and result registers empty.
module smtp_end_of_data_destuffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // message_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic [2:0]  m_tuser,   // byte_valid, message_end, chunk_end
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import smtp_eod_pkg::*;

  logic [LimitW-1:0] chunk_limit_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_start_q;
  logic              can_load, take;
  step_t             step;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegChunkLimit) ? {{(32-LimitW){1'b0}}, chunk_limit_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= ChunkLimitRst;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegChunkLimit)) begin
      chunk_limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign take     = in_valid_q && can_load;
  assign s_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_byte_q  <= s_tdata;
      in_start_q <= s_tuser[0];
    end
  end

  smtp_eod_detect u_detect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (take),
    .data_byte_i     (in_byte_q),
    .message_start_i (in_start_q),
    .chunk_limit_i   (chunk_limit_q),
    .step_o          (step)
  );

  smtp_eod_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take),
    .step_i     (step),
    .can_load_o (can_load),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !can_load |-> !s_tready)
    else $error("input taken while request still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !m_tvalid || (u_outbuf.rem_q != 2'd0))
    else $error("result bank state lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |-> !take || !in_valid_q || (u_outbuf.rem_q != 2'd1))
    else $error("bank overwritten while result stalled");

endmodule

// ----- verif/smtp_eod_checker.sv -----
`timescale 1ns / 100ps
// SMTP destuffer checker: watches every port but prdata, predicts and compares results.
module smtp_eod_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // data_byte
  input  logic [0:0]  s_tuser_i,   // message_start
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // out_byte
  input  logic [2:0]  m_tuser_i,   // byte_valid, message_end, chunk_end
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import smtp_eod_pkg::*;

  phase_e            detect_state;
  logic [CountW-1:0] chunk_fill;
  logic [LimitW-1:0] chunk_size;
  result_t           expected_results[$];
  int                mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic result_t data_result(logic [7:0] b);
    result_t r;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.last        = 1'b0;
    r.message_end = 1'b0;
    r.chunk_end   = 1'b0;
    return r;
  endfunction

  // Advances the detector by one received byte and queues what it delivers.
  function automatic void predict_delivery(logic [7:0] c, logic start);
    logic [7:0] delivered[$];
    phase_e     plain_next;
    result_t    r;
    logic       closing;
    plain_next = (c == ChCr) ? PH_CR : PH_IDLE;
    if (start) begin
      detect_state = PH_IDLE;
      chunk_fill   = '0;
    end
    case (detect_state)
      PH_CR: begin
        delivered.push_back(c);
        detect_state = (c == ChLf) ? PH_CRLF : plain_next;
      end
      PH_CRLF: begin
        if (c == ChDot) begin
          detect_state = PH_CRLF_DOT;
        end else begin
          delivered.push_back(c);
          detect_state = plain_next;
        end
      end
      PH_CRLF_DOT: begin
        if (c == ChCr) begin
          detect_state = PH_CRLF_DOT_CR;
        end else if (c == ChDot) begin
          delivered.push_back(c);
          detect_state = PH_IDLE;
        end else begin
          delivered.push_back(ChDot);
          delivered.push_back(c);
          detect_state = PH_IDLE;
        end
      end
      PH_CRLF_DOT_CR: begin
        if (c == ChLf) begin
          r             = '0;
          r.last        = 1'b1;
          r.message_end = 1'b1;
          expected_results.push_back(r);
          detect_state = PH_IDLE;
          chunk_fill   = '0;
          return;
        end
        delivered.push_back(ChDot);
        delivered.push_back(ChCr);
        delivered.push_back(c);
        detect_state = plain_next;
      end
      default: begin
        delivered.push_back(c);
        detect_state = plain_next;
      end
    endcase
    if (delivered.size() == 0) return;
    chunk_fill = chunk_fill + CountW'(delivered.size());
    closing    = (chunk_fill >= {1'b0, chunk_size});
    if (closing) chunk_fill = '0;
    foreach (delivered[i]) begin
      r = data_result(delivered[i]);
      if (i == delivered.size() - 1) begin
        r.last      = 1'b1;
        r.chunk_end = closing;
      end
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      detect_state = PH_IDLE;
      chunk_fill   = '0;
      chunk_size   = ChunkLimitRst;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[2] == RegChunkLimit) begin
        chunk_size = pwdata_i[LimitW-1:0];
      end
      if (s_tvalid_i && s_tready_i) predict_delivery(s_tdata_i, s_tuser_i[0]);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, byte", m_tdata_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata_i != want.out_byte)
            report_mismatch("out_byte", m_tdata_i, want.out_byte);
          if (m_tuser_i[0] != want.byte_valid)
            report_mismatch("byte_valid", m_tuser_i[0], want.byte_valid);
          if (m_tuser_i[1] != want.message_end)
            report_mismatch("message_end", m_tuser_i[1], want.message_end);
          if (m_tuser_i[2] != want.chunk_end)
            report_mismatch("chunk_end", m_tuser_i[2], want.chunk_end);
          if (m_tlast_i != want.last)
            report_mismatch("last", m_tlast_i, want.last);
        end
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ----- verif/tb_smtp_end_of_data_destuffer.sv -----
`timescale 1ns / 100ps
// Testbench top for the SMTP end-of-data destuffer: clock, reset, stimulus and verdict.
module tb_smtp_end_of_data_destuffer;
  import smtp_eod_pkg::*;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // data_byte
  logic [0:0]  s_tuser  = '0;   // message_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // out_byte
  logic [2:0]  m_tuser;         // byte_valid, message_end, chunk_end
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int tx_burst     = 0;
  int rx_burst     = 0;
  bit tx_no_gaps   = 1'b0;
  bit rx_hold_req  = 1'b0;

  always #5 clk_i = ~clk_i;

  smtp_end_of_data_destuffer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  smtp_eod_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  task automatic send_request(logic [7:0] b, logic start);
    int gap;
    if (tx_no_gaps) begin
      gap = 0;
    end else if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(8, 24);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Mostly line structure around the terminator, with random text between.
  task automatic send_traffic(int n_items);
    logic [7:0] seq[$];
    int         sent;
    int         kind;
    sent = 0;
    while (sent < n_items) begin
      seq.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
        2: seq = '{ChCr, ChLf};
        3: seq = '{ChCr, ChLf, ChDot, ChDot};
        4: seq = '{ChCr, ChLf, ChDot, ChCr, ChLf};
        5: seq = '{ChCr, ChLf, ChDot, 8'($urandom_range(0, 255))};
        6: seq = '{ChCr, ChLf, ChDot, ChCr, 8'($urandom_range(0, 255))};
        7: seq = '{ChCr, ChLf, 8'($urandom_range(0, 255))};
        8: seq = '{ChDot, ChCr};
        default: seq = '{8'($urandom_range(0, 255))};
      endcase
      foreach (seq[i]) send_request(seq[i], $urandom_range(0, 31) == 0);
      sent += seq.size();
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_chunk_limit(logic [15:0] lim);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegChunkLimit, 2'b00};
    pwdata  <= {16'($urandom), lim};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stalls, bursts of full rate, one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        if (rx_burst > 0) begin
          stall = 0;
          rx_burst--;
        end else begin
          stall = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) rx_burst = $urandom_range(8, 24);
        end
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  initial begin
    logic [8:0] directed[$];
    // bit 8 carries message_start
    directed = '{
      {1'b1, 8'h41}, {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, 8'h42},
      {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChDot}, {1'b0, ChDot},
      {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChDot}, {1'b0, 8'hFF},
      {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChDot}, {1'b0, ChCr}, {1'b0, 8'h00},
      {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChDot}, {1'b0, ChCr}, {1'b0, ChCr},
      {1'b0, ChLf}, {1'b0, ChDot}, {1'b0, ChCr}, {1'b0, ChLf},
      {1'b0, ChCr}, {1'b0, ChLf}, {1'b0, ChDot}, {1'b1, 8'h71}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i][7:0], directed[i][8]);
    s_tvalid <= 1'b0;
    drain();

    write_chunk_limit(16'd0);
    send_traffic(20);
    drain();

    write_chunk_limit(16'd1);
    send_traffic(30);
    drain();

    // long output stall while input is offered without gaps
    write_chunk_limit(16'd7);
    rx_hold_req = 1'b1;
    tx_no_gaps  = 1'b1;
    send_traffic(40);
    tx_no_gaps  = 1'b0;
    send_traffic(20);
    drain();

    write_chunk_limit(16'hFFFF);
    send_traffic(30);
    drain();

    write_chunk_limit(16'($urandom_range(2, 40)));
    send_traffic(60);
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
